// ===== rtl/mfek_pkg.sv =====
// Package for the max-flow unit: shared constants, controller states,
// datapath operation codes and the command/status structs. No dependencies.
package mfek_pkg;

    localparam int MAX_NODES_DEF = 256;
    localparam int MAX_EDGES_DEF = 1024;
    localparam int CAP_W_DEF     = 27;

    localparam int NODE_IN_W = 8;
    localparam int CAP_IN_W  = 27;
    localparam int FLOW_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SINK   = 1'b1;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_RUN = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ADD1,
        ST_ADD2,
        ST_SINIT,
        ST_POP,
        ST_P1,
        ST_P2,
        ST_E0,
        ST_E1,
        ST_E2,
        ST_A0,
        ST_A1,
        ST_A2,
        ST_A3,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_DECODE,
        OP_ADD1,
        OP_ADD2,
        OP_SINIT,
        OP_POP,
        OP_P1,
        OP_P2,
        OP_E0,
        OP_E1,
        OP_E2,
        OP_A0,
        OP_A1,
        OP_A2,
        OP_A3
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   latch;
    } mfek_cmd_t;

    typedef struct packed {
        logic run;
        logic add_ok;
        logic full;
        logic trivial;
        logic clr_last;
        logic clr_list;
        logic q_empty;
        logic e_empty;
        logic hit;
        logic path_done;
    } mfek_status_t;

endpackage

// ===== rtl/max_flow_edmonds_karp_unit.sv =====
// Max-flow unit (Edmonds-Karp over a stored residual graph), top level.
// Add word: busy in decode and the two entry writes, no result; a dropped add
// (full table, node out of range) ends at decode. Run word: decode, then per
// search a clear sweep over all nodes, a seed, POP/P1/P2 per popped node, E0-E2
// per edge entry, A0-A3 per augmenting hop; a failing search ends on an empty
// queue; done then pulses one cycle (equal endpoints: after decode), no stall.
module max_flow_edmonds_karp_unit #(
    parameter int MAX_NODES = mfek_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = mfek_pkg::MAX_EDGES_DEF,
    parameter int CAP_W     = mfek_pkg::CAP_W_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            command,
    input  logic [mfek_pkg::NODE_IN_W-1:0]  from_node,
    input  logic [mfek_pkg::NODE_IN_W-1:0]  to_node,
    input  logic [mfek_pkg::CAP_IN_W-1:0]   capacity,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mfek_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfek_pkg::CFG_W-1:0]      cfg_data,
    output logic                            done,
    output logic [mfek_pkg::FLOW_W-1:0]     max_flow,
    output logic                            edges_dropped
);
    import mfek_pkg::*;

    // Reset: busy while the adjacency heads of all nodes are swept
    // empty; configuration writes are taken always.

    mfek_cmd_t    cmd;
    mfek_status_t status;

    // Registers are plain flops in the datapath; take every config word.
    assign cfg_ready = 1'b1;

    // Sequence the load, clear, search and augment steps.
    mfek_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Hold the graph, the search memories and the flow total.
    mfek_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES),
        .CAP_W     (CAP_W)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .command       (command),
        .from_node     (from_node),
        .to_node       (to_node),
        .capacity      (capacity),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .max_flow      (max_flow),
        .edges_dropped (edges_dropped)
    );

endmodule

// ===== rtl/mfek_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfek_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mfek_ctrl.sv =====
// Controller state machine of the max-flow unit.
// Depends on mfek_pkg; drives mfek_dp through mfek_cmd_t.
module mfek_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  mfek_pkg::mfek_status_t status,
    output mfek_pkg::mfek_cmd_t    cmd,
    output logic                  busy,
    output logic                  done
);
    import mfek_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = status.clr_list ? ST_IDLE : ST_SINIT;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.run)
                begin
                    state_next = status.trivial ? ST_DONE : ST_CLEAR;
                end
                else if (status.add_ok && !status.full)
                begin
                    state_next = ST_ADD1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADD1:  state_next = ST_ADD2;
            ST_ADD2:  state_next = ST_IDLE;
            ST_SINIT: state_next = ST_POP;
            ST_POP:   state_next = status.q_empty ? ST_DONE : ST_P1;
            ST_P1:    state_next = ST_P2;
            ST_P2:    state_next = ST_E0;
            ST_E0:    state_next = status.e_empty ? ST_POP : ST_E1;
            ST_E1:    state_next = ST_E2;
            ST_E2:    state_next = status.hit ? ST_A0 : ST_E0;
            ST_A0:    state_next = ST_A1;
            ST_A1:    state_next = ST_A2;
            ST_A2:    state_next = ST_A3;
            ST_A3:    state_next = status.path_done ? ST_CLEAR : ST_A0;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.latch = start && (state_reg == ST_IDLE);
        busy      = (state_reg != ST_IDLE);
        done      = (state_reg == ST_DONE);
        case (state_reg)
            ST_CLEAR:  cmd.op = OP_CLEAR;
            ST_DECODE: cmd.op = OP_DECODE;
            ST_ADD1:   cmd.op = OP_ADD1;
            ST_ADD2:   cmd.op = OP_ADD2;
            ST_SINIT:  cmd.op = OP_SINIT;
            ST_POP:    cmd.op = OP_POP;
            ST_P1:     cmd.op = OP_P1;
            ST_P2:     cmd.op = OP_P2;
            ST_E0:     cmd.op = OP_E0;
            ST_E1:     cmd.op = OP_E1;
            ST_E2:     cmd.op = OP_E2;
            ST_A0:     cmd.op = OP_A0;
            ST_A1:     cmd.op = OP_A1;
            ST_A2:     cmd.op = OP_A2;
            ST_A3:     cmd.op = OP_A3;
            default:   cmd.op = OP_NONE;
        endcase
    end

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("controller did not return to idle after result");

endmodule

// ===== rtl/mfek_dp.sv =====
// Datapath of the max-flow unit: edge tables, adjacency heads, search
// memories, counters and flow accumulator. Depends on mfek_pkg and mfek_ram.
module mfek_dp #(
    parameter int MAX_NODES = mfek_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = mfek_pkg::MAX_EDGES_DEF,
    parameter int CAP_W     = mfek_pkg::CAP_W_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mfek_pkg::mfek_cmd_t                   cmd,
    output mfek_pkg::mfek_status_t                status,
    input  logic                                 command,
    input  logic [mfek_pkg::NODE_IN_W-1:0]       from_node,
    input  logic [mfek_pkg::NODE_IN_W-1:0]       to_node,
    input  logic [mfek_pkg::CAP_IN_W-1:0]        capacity,
    input  logic                                 cfg_valid,
    input  logic [mfek_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mfek_pkg::CFG_W-1:0]           cfg_data,
    output logic [mfek_pkg::FLOW_W-1:0]          max_flow,
    output logic                                 edges_dropped
);
    import mfek_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int SLOTS  = 2 * MAX_EDGES;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LINK_W = SLOT_W + 1;
    localparam int CNT_W  = NODE_W + 1;
    localparam int EXT_W  = (CAP_W > CAP_IN_W) ? CAP_W : CAP_IN_W;
    localparam int SUM_W  = ((CAP_W > FLOW_W) ? CAP_W : FLOW_W) + 1;
    localparam logic [CAP_W-1:0]  CAP_ALL    = {CAP_W{1'b1}};
    localparam logic [LINK_W-1:0] LINK_EMPTY = {1'b1, {SLOT_W{1'b0}}};

    // memory ports
    logic              head_we;
    logic [NODE_W-1:0] head_waddr, head_raddr;
    logic [LINK_W-1:0] head_wdata, head_rdata;
    logic              bn_we;
    logic [NODE_W-1:0] bn_waddr, bn_raddr;
    logic [CAP_W-1:0]  bn_wdata, bn_rdata;
    logic              via_we;
    logic [NODE_W-1:0] via_waddr, via_raddr;
    logic [SLOT_W-1:0] via_wdata, via_rdata;
    logic              que_we;
    logic [NODE_W-1:0] que_waddr, que_raddr;
    logic [NODE_W-1:0] que_wdata, que_rdata;
    logic              edge_we;
    logic [SLOT_W-1:0] edge_waddr, edge_raddr;
    logic [NODE_W-1:0] tgt_wdata, tgt_rdata;
    logic [NODE_W-1:0] org_wdata, org_rdata;
    logic [LINK_W-1:0] lnk_wdata, lnk_rdata;
    logic              res_we;
    logic [SLOT_W-1:0] res_waddr;
    logic [CAP_W-1:0]  res_wdata, res_rdata;

    // control registers
    logic [CFG_W-1:0]  src_reg, src_next;
    logic [CFG_W-1:0]  snk_reg, snk_next;
    logic [SLOT_W:0]   stored_reg, stored_next;
    logic              ovf_reg, ovf_next;
    logic [NODE_W-1:0] clr_reg, clr_next;
    logic              clr_list_reg, clr_list_next;
    logic [CNT_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  wr_reg, wr_next;

    // payload registers
    logic              run_reg, run_next;
    logic              add_ok_reg, add_ok_next;
    logic [NODE_W-1:0] x_reg, x_next;
    logic [NODE_W-1:0] y_reg, y_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [CAP_W-1:0]  bp_reg, bp_next;
    logic [CAP_W-1:0]  r_reg, r_next;
    logic [CAP_W-1:0]  b_reg, b_next;
    logic [LINK_W-1:0] e_reg, e_next;
    logic [LINK_W-1:0] nxt_reg, nxt_next;
    logic [NODE_W-1:0] v_reg, v_next;
    logic [NODE_W-1:0] av_reg, av_next;
    logic [SLOT_W-1:0] ae_reg, ae_next;
    logic [FLOW_W-1:0] total_reg, total_next;

    logic [NODE_W-1:0] s_node, t_node;
    logic [SLOT_W-1:0] slot_even, slot_odd, ae_pair;
    logic [SLOT_W+1:0] stored_plus;
    logic [EXT_W-1:0]  cap_ext;
    logic [CAP_W-1:0]  cap_sat;
    logic [CAP_W-1:0]  mn;
    logic              relax;
    logic              full;
    logic [SUM_W-1:0]  sum;

    assign s_node      = NODE_W'(src_reg);
    assign t_node      = NODE_W'(snk_reg);
    assign slot_even   = stored_reg[SLOT_W-1:0];
    assign slot_odd    = {stored_reg[SLOT_W-1:1], 1'b1};
    assign ae_pair     = {ae_reg[SLOT_W-1:1], ~ae_reg[0]};
    assign stored_plus = {1'b0, stored_reg} + (SLOT_W+2)'(2);
    assign full        = stored_plus > (SLOT_W+2)'(SLOTS);
    assign cap_ext     = EXT_W'(capacity);
    assign cap_sat     = (cap_ext > EXT_W'(CAP_ALL)) ? CAP_ALL : CAP_W'(cap_ext);
    assign relax       = (bn_rdata == '0) && (r_reg != '0);
    assign mn          = (bp_reg < r_reg) ? bp_reg : r_reg;
    assign sum         = SUM_W'(total_reg) + SUM_W'(b_reg);

    always_comb
    begin
        status.run       = run_reg;
        status.add_ok    = add_ok_reg;
        status.full      = full;
        status.trivial   = !((32'(src_reg) < 32'(MAX_NODES))
                           && (32'(snk_reg) < 32'(MAX_NODES))
                           && (src_reg != snk_reg));
        status.clr_last  = (clr_reg == NODE_W'(MAX_NODES - 1));
        status.clr_list  = clr_list_reg;
        status.q_empty   = (rd_reg == wr_reg);
        status.e_empty   = e_reg[SLOT_W];
        status.hit       = relax && (v_reg == t_node);
        status.path_done = (av_reg == s_node);
    end

    always_comb
    begin
        head_we = 1'b0; head_waddr = '0; head_wdata = '0; head_raddr = '0;
        bn_we   = 1'b0; bn_waddr   = '0; bn_wdata   = '0; bn_raddr   = '0;
        via_we  = 1'b0; via_waddr  = '0; via_wdata  = '0; via_raddr  = av_reg;
        que_we  = 1'b0; que_waddr  = '0; que_wdata  = '0;
        que_raddr = rd_reg[NODE_W-1:0];
        edge_we = 1'b0; edge_waddr = '0; edge_raddr = '0;
        tgt_wdata = '0; org_wdata = '0; lnk_wdata = '0;
        res_we  = 1'b0; res_waddr  = '0; res_wdata  = '0;

        src_next = src_reg;   snk_next = snk_reg;
        stored_next = stored_reg; ovf_next = ovf_reg;
        clr_next = clr_reg;   clr_list_next = clr_list_reg;
        rd_next = rd_reg;     wr_next = wr_reg;
        run_next = run_reg;   add_ok_next = add_ok_reg;
        x_next = x_reg;       y_next = y_reg;   cap_next = cap_reg;
        bp_next = bp_reg;     r_next = r_reg;   b_next = b_reg;
        e_next = e_reg;       nxt_next = nxt_reg;
        v_next = v_reg;       av_next = av_reg; ae_next = ae_reg;
        total_next = total_reg;

        if (cfg_valid)
        begin
            if (cfg_index == REG_SOURCE)
            begin
                src_next = cfg_data;
            end
            else
            begin
                snk_next = cfg_data;
            end
        end

        if (cmd.latch)
        begin
            run_next    = (command == CMD_RUN);
            add_ok_next = (32'(from_node) < 32'(MAX_NODES))
                          && (32'(to_node) < 32'(MAX_NODES));
            x_next      = NODE_W'(from_node);
            y_next      = NODE_W'(to_node);
            cap_next    = cap_sat;
        end

        case (cmd.op)
            OP_CLEAR:
            begin
                bn_we      = 1'b1;
                bn_waddr   = clr_reg;
                head_we    = clr_list_reg;
                head_waddr = clr_reg;
                head_wdata = LINK_EMPTY;
                if (status.clr_last)
                begin
                    clr_next      = '0;
                    clr_list_next = 1'b0;
                end
                else
                begin
                    clr_next = clr_reg + NODE_W'(1);
                end
            end
            OP_DECODE:
            begin
                total_next = '0;
                head_raddr = x_reg;
                if (!run_reg && add_ok_reg && full)
                begin
                    ovf_next = 1'b1;
                end
            end
            OP_ADD1:
            begin
                edge_we    = 1'b1;
                edge_waddr = slot_even;
                org_wdata  = x_reg;
                tgt_wdata  = y_reg;
                lnk_wdata  = head_rdata;
                res_we     = 1'b1;
                res_waddr  = slot_even;
                res_wdata  = cap_reg;
                head_we    = 1'b1;
                head_waddr = x_reg;
                head_wdata = {1'b0, slot_even};
                head_raddr = y_reg;
            end
            OP_ADD2:
            begin
                edge_we    = 1'b1;
                edge_waddr = slot_odd;
                org_wdata  = y_reg;
                tgt_wdata  = x_reg;
                // a self loop sees the head just written by the forward entry
                lnk_wdata  = (y_reg == x_reg) ? {1'b0, slot_even} : head_rdata;
                res_we     = 1'b1;
                res_waddr  = slot_odd;
                head_we    = 1'b1;
                head_waddr = y_reg;
                head_wdata = {1'b0, slot_odd};
                stored_next = stored_plus[SLOT_W:0];
            end
            OP_SINIT:
            begin
                bn_we     = 1'b1;
                bn_waddr  = s_node;
                bn_wdata  = CAP_ALL;
                que_we    = 1'b1;
                que_waddr = '0;
                que_wdata = s_node;
                rd_next   = '0;
                wr_next   = CNT_W'(1);
            end
            OP_POP:
            begin
                if (!status.q_empty)
                begin
                    rd_next = rd_reg + CNT_W'(1);
                end
            end
            OP_P1:
            begin
                head_raddr = que_rdata;
                bn_raddr   = que_rdata;
            end
            OP_P2:
            begin
                bp_next = bn_rdata;
                e_next  = head_rdata;
            end
            OP_E0:
            begin
                edge_raddr = e_reg[SLOT_W-1:0];
            end
            OP_E1:
            begin
                v_next   = tgt_rdata;
                r_next   = res_rdata;
                nxt_next = lnk_rdata;
                bn_raddr = tgt_rdata;
            end
            OP_E2:
            begin
                e_next = nxt_reg;
                if (relax)
                begin
                    via_we    = 1'b1;
                    via_waddr = v_reg;
                    via_wdata = e_reg[SLOT_W-1:0];
                    bn_we     = 1'b1;
                    bn_waddr  = v_reg;
                    bn_wdata  = mn;
                    if (wr_reg < CNT_W'(MAX_NODES))
                    begin
                        que_we    = 1'b1;
                        que_waddr = wr_reg[NODE_W-1:0];
                        que_wdata = v_reg;
                        wr_next   = wr_reg + CNT_W'(1);
                    end
                end
                if (status.hit)
                begin
                    b_next  = mn;
                    av_next = t_node;
                end
            end
            OP_A1:
            begin
                ae_next    = via_rdata;
                edge_raddr = via_rdata;
            end
            OP_A2:
            begin
                res_we     = 1'b1;
                res_waddr  = ae_reg;
                res_wdata  = res_rdata - b_reg;
                av_next    = org_rdata;
                edge_raddr = ae_pair;
            end
            OP_A3:
            begin
                res_we    = 1'b1;
                res_waddr = ae_pair;
                res_wdata = res_rdata + b_reg;
                if (status.path_done)
                begin
                    total_next = (|sum[SUM_W-1:FLOW_W]) ? {FLOW_W{1'b1}}
                                                        : sum[FLOW_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg      <= '0;
            snk_reg      <= CFG_W'(1);
            stored_reg   <= '0;
            ovf_reg      <= 1'b0;
            clr_reg      <= '0;
            clr_list_reg <= 1'b1;
            rd_reg       <= '0;
            wr_reg       <= '0;
        end
        else
        begin
            src_reg      <= src_next;
            snk_reg      <= snk_next;
            stored_reg   <= stored_next;
            ovf_reg      <= ovf_next;
            clr_reg      <= clr_next;
            clr_list_reg <= clr_list_next;
            rd_reg       <= rd_next;
            wr_reg       <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg    <= run_next;
        add_ok_reg <= add_ok_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        cap_reg    <= cap_next;
        bp_reg     <= bp_next;
        r_reg      <= r_next;
        b_reg      <= b_next;
        e_reg      <= e_next;
        nxt_reg    <= nxt_next;
        v_reg      <= v_next;
        av_reg     <= av_next;
        ae_reg     <= ae_next;
        total_reg  <= total_next;
    end

    assign max_flow      = total_reg;
    assign edges_dropped = ovf_reg;

    mfek_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata));

    mfek_ram #(.WIDTH(CAP_W), .DEPTH(MAX_NODES)) u_bottleneck (
        .clk(clk), .we(bn_we), .waddr(bn_waddr), .wdata(bn_wdata),
        .raddr(bn_raddr), .rdata(bn_rdata));

    mfek_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_NODES)) u_via (
        .clk(clk), .we(via_we), .waddr(via_waddr), .wdata(via_wdata),
        .raddr(via_raddr), .rdata(via_rdata));

    mfek_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
        .clk(clk), .we(que_we), .waddr(que_waddr), .wdata(que_wdata),
        .raddr(que_raddr), .rdata(que_rdata));

    mfek_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_target (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(tgt_wdata),
        .raddr(edge_raddr), .rdata(tgt_rdata));

    mfek_ram #(.WIDTH(NODE_W), .DEPTH(SLOTS)) u_origin (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(org_wdata),
        .raddr(edge_raddr), .rdata(org_rdata));

    mfek_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_link (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(lnk_wdata),
        .raddr(edge_raddr), .rdata(lnk_rdata));

    mfek_ram #(.WIDTH(CAP_W), .DEPTH(SLOTS)) u_residual (
        .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
        .raddr(edge_raddr), .rdata(res_rdata));

    a_stored_even: assert property (@(posedge clk) disable iff (!rst_n)
        (stored_reg[0] == 1'b0) && ((SLOT_W+2)'(stored_reg) <= (SLOT_W+2)'(SLOTS)))
        else $error("edge slot count odd or beyond table");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        rd_reg <= wr_reg)
        else $error("queue read pointer passed write pointer");

    a_total_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_A3 && status.path_done) |=> total_reg >= $past(total_reg))
        else $error("flow total decreased on augment");

endmodule
